FILE: rtl/ilfu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilfu_pkg
// shared types and constants of the incident line fdtd update block
// ----------------------------------------------------------------------------
package ilfu_pkg;

  // line geometry
  localparam int unsigned CELLS   = 64;
  localparam int unsigned H_DEPTH = CELLS - 1;
  localparam int unsigned E_AW    = $clog2(CELLS);
  localparam int unsigned H_AW    = $clog2(H_DEPTH);

  // field widths
  localparam int unsigned SW     = 16;               // q1.15 sample
  localparam int unsigned CW     = 18;               // multiplier operand
  localparam int unsigned SCW    = 17;               // projection scale
  localparam int unsigned BCW    = 17;               // mur factor
  localparam int unsigned FW     = 16;               // cell fraction
  localparam int unsigned IDX_W  = 6;                // cell index
  localparam int unsigned COMP_W = 2;
  localparam int unsigned IXW    = ((IDX_W > E_AW) ? IDX_W : E_AW) + 1;
  localparam int unsigned PW     = 2 * CW;           // product width
  localparam int unsigned FRAC_BITS = 16;

  // configuration port
  localparam int unsigned CFG_DW = 18;
  localparam int unsigned CFG_IW = 3;

  localparam logic [CFG_IW-1:0] REG_E_KEEP   = 3'd0;
  localparam logic [CFG_IW-1:0] REG_E_CURL   = 3'd1;
  localparam logic [CFG_IW-1:0] REG_H_KEEP   = 3'd2;
  localparam logic [CFG_IW-1:0] REG_H_CURL   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_BOUNDARY = 3'd4;
  localparam logic [CFG_IW-1:0] REG_EZ_SCALE = 3'd5;
  localparam logic [CFG_IW-1:0] REG_HX_SCALE = 3'd6;
  localparam logic [CFG_IW-1:0] REG_HY_SCALE = 3'd7;

  localparam logic [CW-1:0]  RST_E_KEEP   = 18'h10000;
  localparam logic [CW-1:0]  RST_E_CURL   = 18'h38000;
  localparam logic [CW-1:0]  RST_H_KEEP   = 18'h10000;
  localparam logic [CW-1:0]  RST_H_CURL   = 18'h38000;
  localparam logic [BCW-1:0] RST_BOUNDARY = 17'h08000;
  localparam logic [SCW-1:0] RST_EZ_SCALE = 17'h0ffff;
  localparam logic [SCW-1:0] RST_HX_SCALE = 17'h00000;
  localparam logic [SCW-1:0] RST_HY_SCALE = 17'h0ffff;

  // item codes
  localparam logic ACT_ADVANCE = 1'b0;
  localparam logic ACT_QUERY   = 1'b1;

  localparam logic [COMP_W-1:0] COMP_EZ = 2'd0;
  localparam logic [COMP_W-1:0] COMP_HX = 2'd1;
  localparam logic [COMP_W-1:0] COMP_HY = 2'd2;

  // unity in q2.16 and one in the fraction domain
  localparam logic [CW-1:0]   UNITY    = 18'h10000;
  localparam logic [FW:0]     FRAC_ONE = 17'h10000;

  // destination of a finished multiply-accumulate job
  typedef enum logic [1:0] {
    DST_E,
    DST_H,
    DST_CAP
  } dst_e;

  typedef struct packed {
    dst_e            dst;
    logic [E_AW-1:0] addr;
    logic            fin;
  } mac_tag_t;

  typedef struct packed {
    logic                 vld;
    logic                 first;
    logic signed [CW-1:0] coef;
    logic signed [CW-1:0] opnd;
    mac_tag_t             tag;
  } mac_op_t;

  typedef struct packed {
    logic                 vld;
    logic signed [SW-1:0] value;
    mac_tag_t             tag;
  } mac_res_t;

endpackage

FILE: rtl/ilfu_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilfu_mac
// shared multiply-accumulate unit: two products per job, round half up,
// saturate to q1.15
// ----------------------------------------------------------------------------
module ilfu_mac (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ilfu_pkg::mac_op_t  op_i,
  output ilfu_pkg::mac_res_t res_o
);
  import ilfu_pkg::*;

  localparam logic [PW:0] RND_HALF = (PW + 1)'(1) << (FRAC_BITS - 1);

  logic signed [PW-1:0] prod_d;
  logic signed [PW-1:0] prod_q;
  logic                 prod_vld_q;
  logic                 prod_first_q;
  mac_tag_t             prod_tag_q;

  logic signed [PW:0]   acc_d;
  logic signed [PW:0]   acc_q;
  logic                 res_vld_q;
  mac_tag_t             res_tag_q;

  logic signed [PW:0]   rnd;
  logic                 fits;

  assign prod_d = op_i.coef * op_i.opnd;

  // first product of a job loads, second one adds
  assign acc_d = prod_first_q ? {prod_q[PW-1], prod_q}
                              : acc_q + {prod_q[PW-1], prod_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q   <= 1'b0;
      prod_first_q <= 1'b0;
      res_vld_q    <= 1'b0;
    end else begin
      prod_vld_q   <= op_i.vld;
      prod_first_q <= op_i.first;
      res_vld_q    <= prod_vld_q & ~prod_first_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q     <= prod_d;
    prod_tag_q <= op_i.tag;
    res_tag_q  <= prod_tag_q;
    if (prod_vld_q) begin
      acc_q <= acc_d;
    end
  end

  // floor(acc / 2^16 + 1/2), then clamp
  assign rnd  = acc_q + RND_HALF;
  assign fits = (&rnd[PW:FRAC_BITS+SW-1]) | ~(|rnd[PW:FRAC_BITS+SW-1]);

  always_comb begin
    res_o.vld = res_vld_q;
    res_o.tag = res_tag_q;
    if (fits) begin
      res_o.value = rnd[FRAC_BITS+SW-1:FRAC_BITS];
    end else if (rnd[PW]) begin
      res_o.value = {1'b1, {(SW-1){1'b0}}};
    end else begin
      res_o.value = {1'b0, {(SW-1){1'b1}}};
    end
  end

endmodule

FILE: rtl/incident_line_fdtd_update_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// incident_line_fdtd_update_top
// 1d auxiliary fdtd line with first-order mur boundary and interpolated
// field lookup
// ----------------------------------------------------------------------------
// An item is taken when start is high while busy is low; busy then stays
// high until the item is done, and exactly one result word follows on
// field_value_o, marked by a one-cycle done_o strobe in the first cycle with
// busy low again. The receiver cannot stall: done_o is high for that single
// cycle, and field_value_o holds the word until the next item finishes. In
// an advance, cell 0 takes the source sample and every other electric and
// magnetic cell is a two-product job on the single 18x18 multiply-accumulate
// unit, issued one product per cycle except during a short wait before the
// mur boundary for the freshly updated neighbour and a drain at the end; its
// word is always zero. A query runs two scaling jobs, then the interpolation
// job that depends on both. The line storage comes up as all zero right after
// reset with no clearing pass (per-entry valid bits).
// Configuration writes take effect at once and must only be made while the
// block is idle.
// ----------------------------------------------------------------------------
module incident_line_fdtd_update_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command side
  input  logic                          start,
  output logic                          busy,
  input  logic                          action_i,
  input  logic signed [ilfu_pkg::SW-1:0] source_sample_i,
  input  logic [ilfu_pkg::COMP_W-1:0]   component_i,
  input  logic [ilfu_pkg::IDX_W-1:0]    cell_index_i,
  input  logic [ilfu_pkg::FW-1:0]       cell_fraction_i,
  // result side
  output logic                          done_o,
  output logic signed [ilfu_pkg::SW-1:0] field_value_o,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [ilfu_pkg::CFG_IW-1:0]   cfg_idx_i,
  input  logic [ilfu_pkg::CFG_DW-1:0]   cfg_wdata_i
);
  import ilfu_pkg::*;

  // sequencer states
  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_E_PRE   = 5'd1;
  localparam logic [4:0] ST_E_A     = 5'd2;
  localparam logic [4:0] ST_E_B     = 5'd3;
  localparam logic [4:0] ST_BD_WAIT = 5'd4;
  localparam logic [4:0] ST_BD_A    = 5'd5;
  localparam logic [4:0] ST_BD_B    = 5'd6;
  localparam logic [4:0] ST_H_PRE   = 5'd7;
  localparam logic [4:0] ST_H_A     = 5'd8;
  localparam logic [4:0] ST_H_B     = 5'd9;
  localparam logic [4:0] ST_Q_A0    = 5'd10;
  localparam logic [4:0] ST_Q_B0    = 5'd11;
  localparam logic [4:0] ST_Q_A1    = 5'd12;
  localparam logic [4:0] ST_Q_B1    = 5'd13;
  localparam logic [4:0] ST_Q_WAIT  = 5'd14;
  localparam logic [4:0] ST_Q_C0    = 5'd15;
  localparam logic [4:0] ST_Q_C1    = 5'd16;
  localparam logic [4:0] ST_DRAIN   = 5'd17;

  localparam logic [E_AW-1:0] E_LAST     = E_AW'(CELLS - 1);
  localparam logic [E_AW-1:0] E_INNER    = E_AW'(CELLS - 2);
  localparam logic [E_AW-1:0] H_LAST_CNT = E_AW'(H_DEPTH - 1);

  // saturate a cell address onto the last entry of each line
  function automatic logic [E_AW-1:0] cap_e(input logic [IXW-1:0] v);
    logic [E_AW-1:0] r;
    if (v > IXW'(CELLS - 1)) begin
      r = E_LAST;
    end else begin
      r = v[E_AW-1:0];
    end
    return r;
  endfunction

  function automatic logic [H_AW-1:0] cap_h(input logic [IXW-1:0] v);
    logic [H_AW-1:0] r;
    if (v > IXW'(H_DEPTH - 1)) begin
      r = H_AW'(H_DEPTH - 1);
    end else begin
      r = v[H_AW-1:0];
    end
    return r;
  endfunction

  // configuration registers
  logic signed [CW-1:0]  e_keep_q, e_curl_q, h_keep_q, h_curl_q;
  logic [BCW-1:0]        bnd_coef_q;
  logic signed [SCW-1:0] ez_scale_q, hx_scale_q, hy_scale_q;

  // sequencer
  logic [4:0]            st_q, st_d;
  logic [E_AW-1:0]       cnt_q, cnt_d;
  logic signed [SW-1:0]  car_q, car_d;     // neighbour carried between cells
  logic signed [SW-1:0]  a_q, b_q;         // scaled query samples
  logic                  act_q;
  logic [COMP_W-1:0]     comp_q;
  logic [IDX_W-1:0]      idx_q;
  logic [FW-1:0]         frac_q;

  // result word
  logic                  done_q;
  logic signed [SW-1:0]  fv_q;

  // line storage
  logic signed [SW-1:0]  e_mem [CELLS];
  logic signed [SW-1:0]  h_mem [H_DEPTH];
  logic [CELLS-1:0]      e_vld_q;
  logic [H_DEPTH-1:0]    h_vld_q;
  logic signed [SW-1:0]  e_rd_q, h_rd_q;

  logic                  e_re, h_re;
  logic [E_AW-1:0]       e_raddr;
  logic [H_AW-1:0]       h_raddr;
  logic                  e_we, h_we, src_we;
  logic [E_AW-1:0]       e_waddr;
  logic [H_AW-1:0]       h_waddr;
  logic signed [SW-1:0]  e_wdata;

  // shared unit
  mac_op_t               op;
  mac_res_t              res;
  logic                  fin_evt;

  // query helpers
  logic signed [SCW-1:0] scale;
  logic signed [SW-1:0]  line_rd;
  logic [IXW-1:0]        in_lo, q_hi;
  logic [FW:0]           frac_lo_w;
  logic signed [SW:0]    diff_h, diff_e, diff_bd;

  assign busy          = (st_q != ST_IDLE);
  assign done_o        = done_q;
  assign field_value_o = fv_q;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_keep_q   <= RST_E_KEEP;
      e_curl_q   <= RST_E_CURL;
      h_keep_q   <= RST_H_KEEP;
      h_curl_q   <= RST_H_CURL;
      bnd_coef_q <= RST_BOUNDARY;
      ez_scale_q <= RST_EZ_SCALE;
      hx_scale_q <= RST_HX_SCALE;
      hy_scale_q <= RST_HY_SCALE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_E_KEEP:   e_keep_q   <= cfg_wdata_i[CW-1:0];
        REG_E_CURL:   e_curl_q   <= cfg_wdata_i[CW-1:0];
        REG_H_KEEP:   h_keep_q   <= cfg_wdata_i[CW-1:0];
        REG_H_CURL:   h_curl_q   <= cfg_wdata_i[CW-1:0];
        REG_BOUNDARY: bnd_coef_q <= cfg_wdata_i[BCW-1:0];
        REG_EZ_SCALE: ez_scale_q <= cfg_wdata_i[SCW-1:0];
        REG_HX_SCALE: hx_scale_q <= cfg_wdata_i[SCW-1:0];
        REG_HY_SCALE: hy_scale_q <= cfg_wdata_i[SCW-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------ datapath
  // component code 3 gets a zero scale, so the whole query collapses to 0
  always_comb begin
    case (comp_q)
      COMP_EZ: scale = ez_scale_q;
      COMP_HX: scale = hx_scale_q;
      COMP_HY: scale = hy_scale_q;
      default: scale = '0;
    endcase
  end

  assign line_rd   = (comp_q == COMP_EZ) ? e_rd_q : h_rd_q;
  assign in_lo     = IXW'(cell_index_i);
  assign q_hi      = IXW'(idx_q) + 1'b1;
  assign frac_lo_w = FRAC_ONE - {1'b0, frac_q};

  // neighbour differences, one bit wider than a sample
  assign diff_h  = {h_rd_q[SW-1], h_rd_q} - {car_q[SW-1], car_q};
  assign diff_e  = {e_rd_q[SW-1], e_rd_q} - {car_q[SW-1], car_q};
  assign diff_bd = {car_q[SW-1], car_q} - {e_rd_q[SW-1], e_rd_q};

  assign fin_evt = res.vld & res.tag.fin;

  // ------------------------------------------------------------ sequencer
  always_comb begin
    st_d    = st_q;
    cnt_d   = cnt_q;
    car_d   = car_q;
    e_re    = 1'b0;
    e_raddr = '0;
    h_re    = 1'b0;
    h_raddr = '0;
    src_we  = 1'b0;
    op      = '0;

    case (st_q)
      ST_IDLE: begin
        if (start) begin
          if (action_i == ACT_QUERY) begin
            // lower cell of the pair
            if (component_i == COMP_EZ) begin
              e_re    = 1'b1;
              e_raddr = cap_e(in_lo);
            end else begin
              h_re    = 1'b1;
              h_raddr = cap_h(in_lo);
            end
            st_d = ST_Q_A0;
          end else begin
            // source into cell 0, fetch h[0] for the first difference
            src_we  = 1'b1;
            h_re    = 1'b1;
            h_raddr = '0;
            st_d    = ST_E_PRE;
          end
        end
      end

      ST_E_PRE: begin
        car_d   = h_rd_q;
        e_re    = 1'b1;
        e_raddr = E_AW'(1);
        h_re    = 1'b1;
        h_raddr = H_AW'(1);
        cnt_d   = E_AW'(1);
        st_d    = ST_E_A;
      end

      // inner electric cell: keep * e[i]
      ST_E_A: begin
        op.vld   = 1'b1;
        op.first = 1'b1;
        op.coef  = e_keep_q;
        op.opnd  = CW'(e_rd_q);
        st_d     = ST_E_B;
      end

      // + curl * (h[i] - h[i-1]), fetch next cell meanwhile
      ST_E_B: begin
        op.vld      = 1'b1;
        op.coef     = e_curl_q;
        op.opnd     = CW'(diff_h);
        op.tag.dst  = DST_E;
        op.tag.addr = cnt_q;
        car_d       = h_rd_q;
        if (cnt_q == E_INNER) begin
          e_re    = 1'b1;
          e_raddr = E_LAST;
          st_d    = ST_BD_WAIT;
        end else begin
          e_re    = 1'b1;
          e_raddr = cnt_q + 1'b1;
          h_re    = 1'b1;
          h_raddr = H_AW'(cnt_q + 1'b1);
          cnt_d   = cnt_q + 1'b1;
          st_d    = ST_E_A;
        end
      end

      // mur needs the new neighbour straight from the unit
      ST_BD_WAIT: begin
        if (res.vld) begin
          car_d = res.value;
          st_d  = ST_BD_A;
        end
      end

      ST_BD_A: begin
        op.vld   = 1'b1;
        op.first = 1'b1;
        op.coef  = UNITY;
        op.opnd  = CW'(e_rd_q);
        st_d     = ST_BD_B;
      end

      // - boundary * (last - neighbour), start the magnetic sweep
      ST_BD_B: begin
        op.vld      = 1'b1;
        op.coef     = CW'(bnd_coef_q);
        op.opnd     = CW'(diff_bd);
        op.tag.dst  = DST_E;
        op.tag.addr = E_LAST;
        e_re        = 1'b1;
        e_raddr     = '0;
        st_d        = ST_H_PRE;
      end

      ST_H_PRE: begin
        car_d   = e_rd_q;
        e_re    = 1'b1;
        e_raddr = E_AW'(1);
        h_re    = 1'b1;
        h_raddr = '0;
        cnt_d   = '0;
        st_d    = ST_H_A;
      end

      ST_H_A: begin
        op.vld   = 1'b1;
        op.first = 1'b1;
        op.coef  = h_keep_q;
        op.opnd  = CW'(h_rd_q);
        st_d     = ST_H_B;
      end

      ST_H_B: begin
        op.vld      = 1'b1;
        op.coef     = h_curl_q;
        op.opnd     = CW'(diff_e);
        op.tag.dst  = DST_H;
        op.tag.addr = cnt_q;
        car_d       = e_rd_q;
        if (cnt_q == H_LAST_CNT) begin
          op.tag.fin = 1'b1;
          st_d       = ST_DRAIN;
        end else begin
          e_re    = 1'b1;
          e_raddr = cnt_q + E_AW'(2);
          h_re    = 1'b1;
          h_raddr = H_AW'(cnt_q + 1'b1);
          cnt_d   = cnt_q + 1'b1;
          st_d    = ST_H_A;
        end
      end

      // scaled lower sample, fetch the upper one
      ST_Q_A0: begin
        op.vld   = 1'b1;
        op.first = 1'b1;
        op.coef  = CW'(scale);
        op.opnd  = CW'(line_rd);
        if (comp_q == COMP_EZ) begin
          e_re    = 1'b1;
          e_raddr = cap_e(q_hi);
        end else begin
          h_re    = 1'b1;
          h_raddr = cap_h(q_hi);
        end
        st_d = ST_Q_B0;
      end

      ST_Q_B0: begin
        op.vld      = 1'b1;
        op.tag.dst  = DST_CAP;
        op.tag.addr = '0;
        st_d        = ST_Q_A1;
      end

      ST_Q_A1: begin
        op.vld   = 1'b1;
        op.first = 1'b1;
        op.coef  = CW'(scale);
        op.opnd  = CW'(line_rd);
        st_d     = ST_Q_B1;
      end

      ST_Q_B1: begin
        op.vld      = 1'b1;
        op.tag.dst  = DST_CAP;
        op.tag.addr = E_AW'(1);
        st_d        = ST_Q_WAIT;
      end

      // upper sample lands here
      ST_Q_WAIT: begin
        if (res.vld) begin
          st_d = ST_Q_C0;
        end
      end

      ST_Q_C0: begin
        op.vld   = 1'b1;
        op.first = 1'b1;
        op.coef  = CW'(frac_lo_w);
        op.opnd  = CW'(a_q);
        st_d     = ST_Q_C1;
      end

      ST_Q_C1: begin
        op.vld      = 1'b1;
        op.coef     = CW'(frac_q);
        op.opnd     = CW'(b_q);
        op.tag.dst  = DST_CAP;
        op.tag.fin  = 1'b1;
        st_d        = ST_DRAIN;
      end

      ST_DRAIN: begin
        if (fin_evt) begin
          st_d = ST_IDLE;
        end
      end

      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      done_q <= fin_evt;
    end
  end

  always_ff @(posedge clk_i) begin
    car_q <= car_d;
    if (st_q == ST_IDLE && start) begin
      act_q  <= action_i;
      comp_q <= component_i;
      idx_q  <= cell_index_i;
      frac_q <= cell_fraction_i;
    end
    if (res.vld && res.tag.dst == DST_CAP) begin
      if (res.tag.addr[0]) begin
        b_q <= res.value;
      end else begin
        a_q <= res.value;
      end
    end
    // advance words are always zero
    if (fin_evt) begin
      fv_q <= (act_q == ACT_QUERY) ? res.value : '0;
    end
  end

  // --------------------------------------------------------- line storage
  assign e_we    = src_we | (res.vld & (res.tag.dst == DST_E));
  assign e_waddr = src_we ? '0 : res.tag.addr;
  assign e_wdata = src_we ? source_sample_i : res.value;
  assign h_we    = res.vld & (res.tag.dst == DST_H);
  assign h_waddr = H_AW'(res.tag.addr);

  // never-written entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= '0;
      h_vld_q <= '0;
    end else begin
      if (e_we) begin
        e_vld_q[e_waddr] <= 1'b1;
      end
      if (h_we) begin
        h_vld_q[h_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (e_we) begin
      e_mem[e_waddr] <= e_wdata;
    end
    if (e_re) begin
      e_rd_q <= e_vld_q[e_raddr] ? e_mem[e_raddr] : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (h_we) begin
      h_mem[h_waddr] <= res.value;
    end
    if (h_re) begin
      h_rd_q <= h_vld_q[h_raddr] ? h_mem[h_raddr] : '0;
    end
  end

  // ----------------------------------------------------------- mac unit
  ilfu_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (op),
    .res_o  (res)
  );

endmodule

FILE: rtl/ilfu_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilfu_chk
// port-level checks of the command and result sides
// ----------------------------------------------------------------------------
module ilfu_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o
);

  // a taken item always raises busy in the next cycle
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // the word shows exactly when the block has just finished
  a_fall_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("item finished without a result word");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy && $past(busy))
    else $error("result word without a finished item");

  // one word per item, never two in a row
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result word repeated");

endmodule

bind incident_line_fdtd_update_top ilfu_chk u_chk (.*);
